// ----- hw/rtl/gmgc_pkg.sv -----
// gmgc_pkg: shared types, codes and defaults of the gyro motion-gated capture block
// no dependencies

package gmgc_pkg;

    localparam int CAPTURE_DEPTH    = 256;
    localparam int PRETRIGGER_DEPTH = 16;

    // quiet samples kept at the tail when a capture stops
    localparam int TRIM_KEEP = 4;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // phase codes
    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DEADBAND  = 3'd0;
    localparam logic [2:0] REG_WEIGHT    = 3'd1;
    localparam logic [2:0] REG_START_LVL = 3'd2;
    localparam logic [2:0] REG_STOP_LVL  = 3'd3;
    localparam logic [2:0] REG_START_RUN = 3'd4;
    localparam logic [2:0] REG_STOP_RUN  = 3'd5;
    localparam logic [2:0] REG_MIN_LEN   = 3'd6;
    localparam logic [2:0] REG_COOLDOWN  = 3'd7;

    // register reset values
    localparam logic [14:0] RST_DEADBAND  = 15'd16;
    localparam logic [7:0]  RST_WEIGHT    = 8'd204;
    localparam logic [15:0] RST_START_LVL = 16'd240;
    localparam logic [15:0] RST_STOP_LVL  = 16'd96;
    localparam logic [7:0]  RST_START_RUN = 8'd3;
    localparam logic [7:0]  RST_STOP_RUN  = 8'd10;
    localparam logic [8:0]  RST_MIN_LEN   = 9'd20;
    localparam logic [15:0] RST_COOLDOWN  = 16'd1000;

    // one stored sample
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        t;
    } t_entry;

endpackage

// ----- hw/rtl/gyro_motion_gated_capture.sv -----
// gyro_motion_gated_capture: deadband, magnitude, smoothing and motion-gated capture
// depends on gmgc_pkg; holds the pre-trigger ring and the capture store memories
//
// channel   direction  handshake                     payload
// in        into       i_in_valid / o_in_stall       i_op, i_rate_*, i_stamp_ms, i_read_index
// out       out of     o_out_valid / i_out_stall     o_phase ... o_read_ok
// config    into       psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// one item at a time: a sample goes from its accept through the shared multiplier,
// the bit-serial square root, the two average steps, decide, two store reads and
// output before the next accept; a start also copies each pre-trigger ring entry
// through the single store write port, one read and one write per entry
// read, cancel and unused ops: decide, then two registered store reads (last entry, then index)
// synchronous active-low reset clears control state; memory contents stay undefined
// a finished result waits in the output register while o_in_stall drops for the next beat

module gyro_motion_gated_capture #(
    parameter int CAPTURE_DEPTH    = gmgc_pkg::CAPTURE_DEPTH,
    parameter int PRETRIGGER_DEPTH = gmgc_pkg::PRETRIGGER_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beat
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_rate_z,
    input  logic [31:0]        i_stamp_ms,
    input  logic [7:0]         i_read_index,
    // result beat
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_phase,
    output logic               o_done_res,
    output logic               o_aborted,
    output logic [15:0]        o_level,
    output logic [8:0]         o_captured,
    output logic [31:0]        o_span_ms,
    output logic signed [15:0] o_read_x,
    output logic signed [15:0] o_read_y,
    output logic signed [15:0] o_read_z,
    output logic [31:0]        o_read_time,
    output logic               o_read_ok,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
    localparam int LW = $clog2(CAPTURE_DEPTH + 1);
    localparam int RW = (PRETRIGGER_DEPTH > 1) ? $clog2(PRETRIGGER_DEPTH) : 1;
    localparam int FW = $clog2(PRETRIGGER_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_MUL     = 11'b000_0000_0010,
        S_SQRT    = 11'b000_0000_0100,
        S_EMA1    = 11'b000_0000_1000,
        S_EMA2    = 11'b000_0001_0000,
        S_DECIDE  = 11'b000_0010_0000,
        S_COPY_RD = 11'b000_0100_0000,
        S_COPY_WR = 11'b000_1000_0000,
        S_RD_SPAN = 11'b001_0000_0000,
        S_RD_IDX  = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [14:0] r_deadband;
    logic [7:0]  r_weight;
    logic [15:0] r_start_lvl, r_stop_lvl;
    logic [7:0]  r_start_run, r_stop_run;
    logic [8:0]  r_min_len;
    logic [15:0] r_cooldown;

    // block state
    logic [1:0]    r_mode;
    logic [15:0]   r_smoothed;
    logic [7:0]    r_loud, r_quiet;
    logic [LW-1:0] r_len;
    logic [FW-1:0] r_ring_fill;
    logic [RW-1:0] r_ring_wr;
    logic [31:0]   r_blocked;
    logic [31:0]   r_first_t;

    // current item
    logic [1:0]      r_op;
    gmgc_pkg::t_entry r_smp;
    logic [7:0]      r_idx;
    logic [15:0]     r_mag0, r_mag1, r_mag2;
    logic [1:0]      r_mul_cnt;
    logic [31:0]     r_sum;
    logic [31:0]     r_rad;
    logic [19:0]     r_rem;
    logic [15:0]     r_root;
    logic [3:0]      r_sqrt_cnt;
    logic [23:0]     r_old_part;
    logic            r_done, r_abort, r_ok;
    logic [31:0]     r_span;
    logic [FW-1:0]   r_copy_left;
    logic [RW-1:0]   r_ring_rd;

    // memories
    gmgc_pkg::t_entry ring_mem  [PRETRIGGER_DEPTH];
    gmgc_pkg::t_entry store_mem [CAPTURE_DEPTH];
    gmgc_pkg::t_entry r_ring_q, r_store_q;
    logic             ring_we, store_we;
    logic [CW-1:0]    store_waddr, store_raddr;
    gmgc_pkg::t_entry store_wdata;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            gmgc_pkg::REG_DEADBAND:  prdata = {17'd0, r_deadband};
            gmgc_pkg::REG_WEIGHT:    prdata = {24'd0, r_weight};
            gmgc_pkg::REG_START_LVL: prdata = {16'd0, r_start_lvl};
            gmgc_pkg::REG_STOP_LVL:  prdata = {16'd0, r_stop_lvl};
            gmgc_pkg::REG_START_RUN: prdata = {24'd0, r_start_run};
            gmgc_pkg::REG_STOP_RUN:  prdata = {24'd0, r_stop_run};
            gmgc_pkg::REG_MIN_LEN:   prdata = {23'd0, r_min_len};
            gmgc_pkg::REG_COOLDOWN:  prdata = {16'd0, r_cooldown};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= gmgc_pkg::RST_DEADBAND;
            r_weight    <= gmgc_pkg::RST_WEIGHT;
            r_start_lvl <= gmgc_pkg::RST_START_LVL;
            r_stop_lvl  <= gmgc_pkg::RST_STOP_LVL;
            r_start_run <= gmgc_pkg::RST_START_RUN;
            r_stop_run  <= gmgc_pkg::RST_STOP_RUN;
            r_min_len   <= gmgc_pkg::RST_MIN_LEN;
            r_cooldown  <= gmgc_pkg::RST_COOLDOWN;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                gmgc_pkg::REG_DEADBAND:  r_deadband  <= pwdata[14:0];
                gmgc_pkg::REG_WEIGHT:    r_weight    <= pwdata[7:0];
                gmgc_pkg::REG_START_LVL: r_start_lvl <= pwdata[15:0];
                gmgc_pkg::REG_STOP_LVL:  r_stop_lvl  <= pwdata[15:0];
                gmgc_pkg::REG_START_RUN: r_start_run <= pwdata[7:0];
                gmgc_pkg::REG_STOP_RUN:  r_stop_run  <= pwdata[7:0];
                gmgc_pkg::REG_MIN_LEN:   r_min_len   <= pwdata[8:0];
                gmgc_pkg::REG_COOLDOWN:  r_cooldown  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- deadband
    function automatic logic [15:0] band_cut(input logic signed [15:0] v,
                                             input logic [14:0] band);
        logic [16:0] mag;
        mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        if (mag <= {2'b00, band}) return 16'd0;
        return 16'(mag - {2'b00, band});
    endfunction

    // ---------------------------------------------------------------- sum of squares
    logic [31:0] sq_sum;
    assign sq_sum = r_sum + 32'(r_mag0) * 32'(r_mag0);

    // ---------------------------------------------------------------- sqrt step
    logic [19:0] rem_sh, trial;
    assign rem_sh = {r_rem[17:0], r_rad[31:30]};
    assign trial  = {2'b00, r_root, 2'b01};

    // ---------------------------------------------------------------- decision
    logic [RW-1:0] ring_wr_nxt;
    logic [FW-1:0] fill_nxt;
    logic [7:0]    loud_nxt, quiet_nxt, first_w;
    logic          start_go, full, stop_go;
    logic [LW-1:0] len_app, len_trim;

    always_comb begin
        ring_wr_nxt = (32'(r_ring_wr) == PRETRIGGER_DEPTH - 1) ? '0 : r_ring_wr + 1'b1;
        fill_nxt    = (32'(r_ring_fill) < PRETRIGGER_DEPTH) ? r_ring_fill + 1'b1
                                                            : r_ring_fill;
        if (r_smoothed >= r_start_lvl)
            loud_nxt = (r_loud == 8'hFF) ? r_loud : r_loud + 8'd1;
        else
            loud_nxt = 8'd0;
        start_go = (r_smp.t >= r_blocked) && (loud_nxt >= r_start_run);
        // oldest ring entry after this push
        first_w = 8'(ring_wr_nxt) + 8'(PRETRIGGER_DEPTH) - 8'(fill_nxt);
        if (first_w >= 8'(PRETRIGGER_DEPTH))
            first_w = first_w - 8'(PRETRIGGER_DEPTH);

        len_app = r_len + 1'b1;
        if (r_smoothed <= r_stop_lvl)
            quiet_nxt = (r_quiet == 8'hFF) ? r_quiet : r_quiet + 8'd1;
        else
            quiet_nxt = 8'd0;
        full    = 32'(len_app) >= CAPTURE_DEPTH;
        stop_go = (32'(len_app) >= 32'(r_min_len)) && (quiet_nxt >= r_stop_run);
        // keep only the last few quiet samples
        len_trim = len_app;
        if (quiet_nxt > 8'(gmgc_pkg::TRIM_KEEP)
            && 32'(len_app) > 32'(quiet_nxt) - gmgc_pkg::TRIM_KEEP)
            len_trim = LW'(32'(len_app) - (32'(quiet_nxt) - gmgc_pkg::TRIM_KEEP));
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid)
                    n_state = (i_op == gmgc_pkg::OP_SAMPLE) ? S_MUL : S_DECIDE;
            end
            S_MUL:     if (r_mul_cnt == 2'd2) n_state = S_SQRT;
            S_SQRT:    if (r_sqrt_cnt == 4'd15) n_state = S_EMA1;
            S_EMA1:    n_state = S_EMA2;
            S_EMA2:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_op == gmgc_pkg::OP_SAMPLE && r_mode == gmgc_pkg::PH_WAIT && start_go)
                    n_state = S_COPY_RD;
                else
                    n_state = S_RD_SPAN;
            end
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: n_state = (r_copy_left == FW'(1)) ? S_RD_SPAN : S_COPY_RD;
            S_RD_SPAN: n_state = S_RD_IDX;
            S_RD_IDX:  n_state = S_OUT;
            S_OUT:     if (!o_out_valid || !i_out_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // ---------------------------------------------------------------- memory ports
    assign ring_we = (r_state == S_DECIDE) && (r_op == gmgc_pkg::OP_SAMPLE)
                     && (r_mode == gmgc_pkg::PH_WAIT);

    always_comb begin
        store_we    = 1'b0;
        store_waddr = CW'(r_len);
        store_wdata = r_smp;
        if (r_state == S_COPY_WR) begin
            store_we    = 32'(r_len) < CAPTURE_DEPTH;
            store_wdata = r_ring_q;
        end else if (r_state == S_DECIDE && r_op == gmgc_pkg::OP_SAMPLE
                     && r_mode == gmgc_pkg::PH_CAPTURE) begin
            store_we = 32'(r_len) < CAPTURE_DEPTH;
        end
        // last entry for the span, else the requested entry
        store_raddr = (r_state == S_RD_SPAN) ? CW'(r_len - 1'b1) : CW'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) ring_mem[r_ring_wr] <= r_smp;
        r_ring_q <= ring_mem[r_ring_rd];
    end

    always_ff @(posedge i_clk) begin
        if (store_we) store_mem[store_waddr] <= store_wdata;
        r_store_q <= store_mem[store_raddr];
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op      <= i_op;
                r_idx     <= i_read_index;
                r_smp     <= '{x: i_rate_x, y: i_rate_y, z: i_rate_z, t: i_stamp_ms};
                r_mag0    <= band_cut(i_rate_x, r_deadband);
                r_mag1    <= band_cut(i_rate_y, r_deadband);
                r_mag2    <= band_cut(i_rate_z, r_deadband);
                r_sum     <= 32'd0;
                r_mul_cnt <= 2'd0;
            end
            S_MUL: begin
                // one square per cycle through the shared multiplier
                r_sum     <= sq_sum;
                r_mag0    <= r_mag1;
                r_mag1    <= r_mag2;
                r_mul_cnt <= r_mul_cnt + 2'd1;
                r_rad      <= sq_sum;
                r_rem      <= 20'd0;
                r_root     <= 16'd0;
                r_sqrt_cnt <= 4'd0;
            end
            S_SQRT: begin
                r_rad      <= {r_rad[29:0], 2'b00};
                r_sqrt_cnt <= r_sqrt_cnt + 4'd1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[14:0], 1'b0};
                end
            end
            S_EMA1: r_old_part <= r_weight * r_smoothed;
            default: ;
        endcase
    end

    // span and output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD_IDX)
            r_span <= (32'(r_len) >= 2) ? (r_store_q.t - r_first_t) : 32'd0;
        if (r_state == S_OUT && (!o_out_valid || !i_out_stall)) begin
            o_phase    <= r_mode;
            o_done_res <= r_done;
            o_aborted  <= r_abort;
            o_level    <= r_smoothed;
            o_captured <= 9'(r_len);
            o_span_ms  <= r_span;
            o_read_ok  <= r_ok;
            if (r_ok) begin
                o_read_x    <= r_store_q.x;
                o_read_y    <= r_store_q.y;
                o_read_z    <= r_store_q.z;
                o_read_time <= r_store_q.t;
            end else begin
                o_read_x    <= 16'sd0;
                o_read_y    <= 16'sd0;
                o_read_z    <= 16'sd0;
                o_read_time <= 32'd0;
            end
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= gmgc_pkg::PH_WAIT;
            r_smoothed  <= 16'd0;
            r_loud      <= 8'd0;
            r_quiet     <= 8'd0;
            r_len       <= '0;
            r_ring_fill <= '0;
            r_ring_wr   <= '0;
            r_ring_rd   <= '0;
            r_copy_left <= '0;
            r_blocked   <= 32'd0;
            r_first_t   <= 32'd0;
            r_done      <= 1'b0;
            r_abort     <= 1'b0;
            r_ok        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && !i_out_stall)
                o_out_valid <= 1'b0;
            if (store_we && store_waddr == '0)
                r_first_t <= store_wdata.t;

            case (r_state)
                S_EMA2: begin
                    // load directly while the average is zero
                    if (r_smoothed == 16'd0)
                        r_smoothed <= r_root;
                    else
                        r_smoothed <= 16'((25'(r_old_part)
                                      + (9'd256 - {1'b0, r_weight}) * r_root
                                      + 25'd128) >> 8);
                end
                S_DECIDE: begin
                    r_done  <= 1'b0;
                    r_abort <= 1'b0;
                    r_ok    <= (r_op == gmgc_pkg::OP_READ) && (32'(r_idx) < 32'(r_len));
                    case (r_op)
                        gmgc_pkg::OP_SAMPLE: begin
                            if (r_mode == gmgc_pkg::PH_DONE) begin
                                r_done <= 1'b1;
                            end else if (r_mode == gmgc_pkg::PH_WAIT) begin
                                r_ring_wr   <= ring_wr_nxt;
                                r_ring_fill <= fill_nxt;
                                if (r_smp.t >= r_blocked)
                                    r_loud <= loud_nxt;
                                if (start_go) begin
                                    r_mode      <= gmgc_pkg::PH_CAPTURE;
                                    r_len       <= '0;
                                    r_loud      <= 8'd0;
                                    r_quiet     <= 8'd0;
                                    r_copy_left <= fill_nxt;
                                    r_ring_rd   <= RW'(first_w);
                                end
                            end else begin
                                r_quiet <= quiet_nxt;
                                r_len   <= len_app;
                                if (full) begin
                                    // store filled: discard and hold off restart
                                    r_mode      <= gmgc_pkg::PH_WAIT;
                                    r_len       <= '0;
                                    r_ring_fill <= '0;
                                    r_ring_wr   <= '0;
                                    r_loud      <= 8'd0;
                                    r_quiet     <= 8'd0;
                                    r_smoothed  <= 16'd0;
                                    r_blocked   <= r_smp.t + 32'(r_cooldown);
                                    r_abort     <= 1'b1;
                                end else if (stop_go) begin
                                    r_len  <= len_trim;
                                    r_mode <= gmgc_pkg::PH_DONE;
                                    r_done <= 1'b1;
                                end
                            end
                        end
                        gmgc_pkg::OP_CANCEL: begin
                            r_mode      <= gmgc_pkg::PH_WAIT;
                            r_len       <= '0;
                            r_ring_fill <= '0;
                            r_ring_wr   <= '0;
                            r_loud      <= 8'd0;
                            r_quiet     <= 8'd0;
                            r_smoothed  <= 16'd0;
                            r_blocked   <= 32'd0;
                        end
                        default: ;
                    endcase
                end
                S_COPY_WR: begin
                    if (32'(r_len) < CAPTURE_DEPTH)
                        r_len <= r_len + 1'b1;
                    r_copy_left <= r_copy_left - 1'b1;
                    r_ring_rd   <= (32'(r_ring_rd) == PRETRIGGER_DEPTH - 1) ? '0
                                                                          : r_ring_rd + 1'b1;
                end
                S_OUT: begin
                    if (!o_out_valid || !i_out_stall)
                        o_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("fsm state not one-hot");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= CAPTURE_DEPTH) else $error("capture length beyond store");

    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3) else $error("phase out of range");

    a_abort_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_aborted) |-> (o_level == 16'd0 && o_captured == 9'd0
                                        && o_phase == gmgc_pkg::PH_WAIT))
        else $error("aborted beat with live capture state");

    a_wait_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY_WR) |-> (r_copy_left != '0 && r_mode == gmgc_pkg::PH_CAPTURE))
        else $error("ring copy outside a capture start");
`endif

endmodule
